// ===== rtl/jrsm_pkg.sv =====
// ----------------------------------------------------------------------------
// jrsm_pkg: shared types and constants of the JTAG register shift master
// Holds the exchange state, the result record and the sequencing constants.
// ----------------------------------------------------------------------------
package jrsm_pkg;

	localparam int MAX_BITS     = 32;
	localparam int WORD_BITS    = 32;
	localparam int ENTRY_LEN_IR = 5;
	localparam int ENTRY_LEN_DR = 4;
	localparam int EXIT_LEN     = 4;

	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	localparam logic [1:0] KIND_IR = 2'd0;
	localparam logic [1:0] KIND_DR = 2'd1;

	typedef enum logic [1:0] {
		PH_ENTRY = 2'd0,
		PH_SHIFT = 2'd1,
		PH_EXIT  = 2'd2
	} phase_t;

	typedef struct packed {
		logic                 busy;
		phase_t               phase;
		logic [5:0]           step_index;
		logic [WORD_BITS-1:0] shift_out;
		logic [WORD_BITS-1:0] shift_in;
		logic [5:0]           bits_total;
		logic [1:0]           kind_held;
	} state_t;

	typedef struct packed {
		logic                 status;
		logic [WORD_BITS-1:0] received;
		logic                 done_res;
		logic                 tdi_out;
		logic                 tms_out;
		logic                 cycle_valid;
	} result_t;

	typedef struct packed {
		logic       tdo_bit;
		logic [1:0] register_kind;
		logic [5:0] bit_count;
		logic [WORD_BITS-1:0] send_data;
	} request_t;

endpackage

// ===== rtl/jrsm_step.sv =====
// ----------------------------------------------------------------------------
// jrsm_step: next state and result of one request
// Applies a start or a TDO sample to the exchange state, skips empty phases
// and forms the TCK cycle to drive, the done record or a rejection.
// ----------------------------------------------------------------------------
module jrsm_step
	import jrsm_pkg::*;
(
	input  state_t   cur,
	input  logic     action,
	input  request_t req,
	output state_t   nxt,
	output result_t  res
);

	state_t     cand;
	state_t     settled;
	logic       reject;
	logic       live;
	logic [5:0] entry_len;
	logic [5:0] count_sat;

	always_comb begin
		count_sat = ({1'b0, req.bit_count} > 7'(MAX_BITS)) ?
			6'(MAX_BITS) : req.bit_count;
		cand   = cur;
		reject = 1'b0;
		if (action == ACT_START) begin
			if (cur.busy) begin
				reject = 1'b1;
			end else begin
				cand.busy       = 1'b1;
				cand.phase      = PH_ENTRY;
				cand.step_index = '0;
				cand.shift_out  = req.send_data;
				cand.shift_in   = '0;
				cand.bits_total = count_sat;
				cand.kind_held  = req.register_kind;
			end
		end else begin
			if (!cur.busy) begin
				reject = 1'b1;
			end else begin
				// Only shift cycles within the word keep their TDO level.
				if (cur.phase == PH_SHIFT && !cur.step_index[5] && req.tdo_bit) begin
					cand.shift_in = cur.shift_in | (WORD_BITS'(1) << cur.step_index[4:0]);
				end
				cand.step_index = cur.step_index + 6'd1;
			end
		end
	end

	always_comb begin
		if (cand.kind_held == KIND_IR) begin
			entry_len = 6'(ENTRY_LEN_IR);
		end else if (cand.kind_held == KIND_DR) begin
			entry_len = 6'(ENTRY_LEN_DR);
		end else begin
			entry_len = '0;
		end
		settled = cand;
		if (settled.phase == PH_ENTRY && settled.step_index >= entry_len) begin
			settled.phase      = PH_SHIFT;
			settled.step_index = '0;
		end
		if (settled.phase == PH_SHIFT && settled.step_index >= settled.bits_total) begin
			settled.phase      = PH_EXIT;
			settled.step_index = '0;
		end
		live = !(settled.phase == PH_EXIT &&
			(entry_len == '0 || settled.step_index >= 6'(EXIT_LEN)));
	end

	always_comb begin
		res = '0;
		nxt = settled;
		if (reject) begin
			nxt        = cur;
			res.status = 1'b1;
		end else if (live) begin
			res.cycle_valid = 1'b1;
			unique case (settled.phase)
				PH_ENTRY: begin
					if (settled.kind_held == KIND_IR) begin
						res.tms_out = (settled.step_index == 6'd1) || (settled.step_index == 6'd2);
					end else begin
						res.tms_out = (settled.step_index == 6'd1);
					end
				end
				PH_SHIFT: begin
					res.tms_out = ({1'b0, settled.step_index} + 7'd1) == {1'b0, settled.bits_total};
					res.tdi_out = !settled.step_index[5] &&
						settled.shift_out[settled.step_index[4:0]];
				end
				default: begin
					res.tms_out = (settled.step_index == 6'd0);
				end
			endcase
		end else begin
			nxt.busy     = 1'b0;
			res.done_res = 1'b1;
			res.received = settled.shift_in;
		end
	end

endmodule

// ===== rtl/jtag_register_shift_master.sv =====
// ----------------------------------------------------------------------------
// jtag_register_shift_master: JTAG IR/DR exchange sequencer
// Runs one instruction, data or raw register exchange, one TCK cycle per request.
// ----------------------------------------------------------------------------
//  Channel | Direction | Carries
//  s_*     | in        | start request or sampled TDO (tuser selects which)
//  m_*     | out       | next TCK cycle, done record or rejection
//
//  One request is taken per clock while m_tready does not stall the output; its
//  result is captured in the output register, which is the only stage of the path.
//  s_tready is high while the output register is empty or being drained, so
//  a stall on m_tready holds the result and stops intake in the same cycle.
//  Reset clears the exchange state and empties the output register.
module jtag_register_shift_master
	import jrsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// send_data[31:0], bit_count[37:32], register_kind[39:38], tdo_bit[40], zero fill
	input  logic [47:0] s_tdata,
	// action[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cycle_valid[0], tms_out[1], tdi_out[2], done_res[3], received[35:4],
	// status[36], zero fill
	output logic [39:0] m_tdata
);

	state_t   state_q;
	state_t   state_nxt;
	result_t  res;
	result_t  res_q;
	logic     m_tvalid_q;
	logic     accept;
	request_t req;

	assign req      = s_tdata[40:0];
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	jrsm_step u_step (
		.cur    (state_q),
		.action (s_tuser[0]),
		.req    (req),
		.nxt    (state_nxt),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{busy: 1'b0, phase: PH_ENTRY, step_index: '0, shift_out: '0,
				shift_in: '0, bits_total: '0, kind_held: '0};
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			if (s_tready) begin
				m_tvalid_q <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, res_q};

endmodule

// ===== rtl/jrsm_checker.sv =====
// ----------------------------------------------------------------------------
// jrsm_checker: port-level checks of the JTAG register shift master
// Watches the request and result streams and the coding of result records.
// ----------------------------------------------------------------------------
module jrsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// Every accepted request leaves a result in the output register.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted request produced no result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// A rejection carries nothing but its status bit.
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[36] |-> m_tdata[35:0] == 36'd0)
		else $error("rejection with payload");

	// A record is one of cycle, done or rejection, and pins are quiet off a cycle.
	a_record_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot({m_tdata[0], m_tdata[3], m_tdata[36]}) &&
			(m_tdata[0] || m_tdata[2:1] == 2'b00))
		else $error("malformed result record");

endmodule

bind jtag_register_shift_master jrsm_checker u_jrsm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for jtag_register_shift_master
// Drives IR, DR and raw exchanges plus out-of-turn requests through the
// stream input, predicts every TCK cycle, done record and rejection, and
// checks each output beat in order under several handshake pacing profiles.
// ----------------------------------------------------------------------------
module testbench;
	import jrsm_pkg::*;

	localparam logic [1:0] KIND_RAW   = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int         NO_REJECT  = -1;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// send_data[31:0], bit_count[37:32], register_kind[39:38], tdo_bit[40], zero fill
	logic [47:0] s_tdata;
	// action[0]
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// cycle_valid[0], tms_out[1], tdi_out[2], done_res[3], received[35:4],
	// status[36], zero fill
	logic [39:0] m_tdata;

	jtag_register_shift_master dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Predicted TAP sequencer state.
	logic        tap_busy;
	phase_t      tap_phase;
	logic [5:0]  tap_step;
	logic [31:0] tap_send;
	logic [31:0] tap_recv;
	logic [5:0]  tap_bits;
	logic [1:0]  tap_kind;

	result_t pending_cycles[$];

	int send_idle_pct;
	int sink_stall_pct;
	int requests_sent;
	int error_count;
	int done_count;
	int reject_count;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Timeout with %0d results outstanding", pending_cycles.size());
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [5:0] entry_cycles(logic [1:0] kind);
		if (kind == KIND_IR) return 6'(ENTRY_LEN_IR);
		if (kind == KIND_DR) return 6'(ENTRY_LEN_DR);
		return 6'd0;
	endfunction

	function automatic int exchange_len(logic [5:0] cnt, logic [1:0] kind);
		int bits;
		bits = (cnt > MAX_BITS) ? MAX_BITS : int'(cnt);
		if (kind == KIND_IR || kind == KIND_DR) return int'(entry_cycles(kind)) + bits + EXIT_LEN;
		return bits;
	endfunction

	function automatic result_t jtag_next_cycle(logic act, logic [31:0] data, logic [5:0] cnt,
			logic [1:0] kind, logic tdo);
		result_t r;
		logic    framed;
		r = '0;
		if (act == ACT_START) begin
			if (tap_busy) begin
				r.status = 1'b1;
				return r;
			end
			tap_busy  = 1'b1;
			tap_phase = PH_ENTRY;
			tap_step  = 6'd0;
			tap_send  = data;
			tap_recv  = 32'd0;
			tap_bits  = (cnt > MAX_BITS) ? 6'(MAX_BITS) : cnt;
			tap_kind  = kind;
		end else begin
			if (!tap_busy) begin
				r.status = 1'b1;
				return r;
			end
			if (tap_phase == PH_SHIFT && tap_step < WORD_BITS && tdo)
				tap_recv[tap_step[4:0]] = 1'b1;
			tap_step = tap_step + 6'd1;
		end
		// Empty phases are skipped so the result names a real cycle unless the exchange is done.
		framed = (tap_kind == KIND_IR) || (tap_kind == KIND_DR);
		if (tap_phase == PH_ENTRY && tap_step >= entry_cycles(tap_kind)) begin
			tap_phase = PH_SHIFT;
			tap_step  = 6'd0;
		end
		if (tap_phase == PH_SHIFT && tap_step >= tap_bits) begin
			tap_phase = PH_EXIT;
			tap_step  = 6'd0;
		end
		if (tap_phase == PH_EXIT && (!framed || tap_step >= EXIT_LEN)) begin
			tap_busy   = 1'b0;
			r.done_res = 1'b1;
			r.received = tap_recv;
			return r;
		end
		r.cycle_valid = 1'b1;
		case (tap_phase)
			PH_ENTRY: begin
				if (tap_kind == KIND_IR)
					r.tms_out = (tap_step == 6'd1) || (tap_step == 6'd2);
				else
					r.tms_out = (tap_step == 6'd1);
			end
			PH_SHIFT: begin
				r.tms_out = (tap_step + 6'd1 == tap_bits);
				r.tdi_out = (tap_step < WORD_BITS) ? tap_send[tap_step[4:0]] : 1'b0;
			end
			default: r.tms_out = (tap_step == 6'd0);
		endcase
		return r;
	endfunction

	// Every accepted request produces exactly one expected output beat.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			pending_cycles.push_back(jtag_next_cycle(s_tuser[0], s_tdata[31:0], s_tdata[37:32],
				s_tdata[39:38], s_tdata[40]));
	end

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[36:0]);
			if (pending_cycles.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("Unexpected output beat %h with no request outstanding", m_tdata);
			end else begin
				want = pending_cycles.pop_front();
				if (want.done_res) done_count++;
				if (want.status) reject_count++;
				if (want.cycle_valid) cycle_count++;
				if (m_tdata[39:37] != 3'd0 || got.cycle_valid != want.cycle_valid ||
						got.tms_out != want.tms_out || got.tdi_out != want.tdi_out ||
						got.done_res != want.done_res || got.received != want.received ||
						got.status != want.status) begin
					error_count++;
					if (error_count <= 10)
						$display("Mismatch valid/tms/tdi/done/recv/status: exp %b/%b/%b/%b/%h/%b got %b/%b/%b/%b/%h/%b pad %b",
							want.cycle_valid, want.tms_out, want.tdi_out, want.done_res,
							want.received, want.status, got.cycle_valid, got.tms_out,
							got.tdi_out, got.done_res, got.received, got.status,
							m_tdata[39:37]);
				end
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	task automatic send_request(logic act, logic [31:0] data, logic [5:0] cnt, logic [1:0] kind,
			logic tdo);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'd0, tdo, kind, cnt, data};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests_sent++;
	endtask

	task automatic start_exchange(logic [31:0] data, logic [5:0] cnt, logic [1:0] kind);
		send_request(ACT_START, data, cnt, kind, 1'($urandom));
	endtask

	task automatic sample_tdo(logic tdo);
		send_request(ACT_SAMPLE, $urandom, 6'($urandom), 2'($urandom), tdo);
	endtask

	// A start that lands while the exchange runs must be rejected and leave it intact.
	task automatic run_exchange(logic [31:0] data, logic [5:0] cnt, logic [1:0] kind,
			int reject_at);
		int len;
		len = exchange_len(cnt, kind);
		start_exchange(data, cnt, kind);
		for (int i = 0; i < len; i++) begin
			if (i == reject_at) start_exchange($urandom, 6'($urandom), 2'($urandom));
			sample_tdo(1'($urandom));
		end
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_cycles.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		sample_tdo(1'b1);
		start_exchange(32'h0000_0000, 6'd0, KIND_RAW);
		run_exchange(32'hFFFF_FFFF, 6'd0, KIND_IR, 4);
		start_exchange(32'hFFFF_FFFF, 6'd2, KIND_SPARE);
		sample_tdo(1'b1);
		sample_tdo(1'b0);
		run_exchange(32'h0000_0001, 6'd1, KIND_DR, NO_REJECT);
		wait_for_drain();
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		int          first;
		int          pick;
		int          reject_at;
		logic [1:0]  kind;
		logic [5:0]  cnt;
		logic [31:0] data;
		send_idle_pct  = idle_pct;
		sink_stall_pct = stall_pct;
		first = requests_sent;
		while (requests_sent - first < count) begin
			if ($urandom_range(0, 99) < 5) sample_tdo(1'($urandom));
			pick = $urandom_range(0, 9);
			kind = (pick < 4) ? KIND_IR : (pick < 8) ? KIND_DR : (pick == 8) ? KIND_RAW : KIND_SPARE;
			pick = $urandom_range(0, 99);
			if (pick < 6)
				cnt = 6'd32;
			else if (pick < 9)
				cnt = 6'd63;
			else if (pick < 12)
				cnt = 6'($urandom_range(33, 62));
			else
				cnt = 6'($urandom_range(0, 8));
			pick = $urandom_range(0, 9);
			data = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
			reject_at = ($urandom_range(0, 9) == 0) ?
				$urandom_range(0, exchange_len(cnt, kind)) : NO_REJECT;
			run_exchange(data, cnt, kind, reject_at);
		end
	endtask

	initial begin
		tap_busy      = 1'b0;
		tap_phase     = PH_ENTRY;
		tap_step      = 6'd0;
		tap_send      = 32'd0;
		tap_recv      = 32'd0;
		tap_bits      = 6'd0;
		tap_kind      = KIND_IR;
		send_idle_pct = 0;
		sink_stall_pct = 0;
		requests_sent = 0;
		error_count   = 0;
		done_count    = 0;
		reject_count  = 0;
		cycle_count   = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		m_tready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(270, 13, 58);
		wait_for_drain();
		test_random(270, 58, 13);
		wait_for_drain();
		test_random(270, 0, 0);
		wait_for_drain();
		repeat (8) @(posedge clk);

		if (pending_cycles.size() != 0) begin
			error_count++;
			$display("%0d expected results never arrived", pending_cycles.size());
		end
		$display("Sent %0d requests: %0d TCK cycles, %0d finished exchanges, %0d rejections",
			requests_sent, cycle_count, done_count, reject_count);
		$display("Pacing covered slow sink, slow source and back-to-back; %0d mismatches",
			error_count);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
